// ----- hw/rtl/sckt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckt_pkg: shared types and codes of the sorted counted key table
// Widths, op and status codes, and the structs passed between the table
// sequencer, the entry store and the compare/step unit.
// ----------------------------------------------------------------------------
package sckt_pkg;

   // Table size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths
   localparam int OP_W     = 2;
   localparam int KEY_W    = 14;
   localparam int QTY_W    = 16;
   localparam int STATUS_W = 3;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [QTY_W-1:0]    qty_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   // Op codes
   localparam op_type OP_ADD  = 2'd0;
   localparam op_type OP_SUB  = 2'd1;
   localparam op_type OP_LIST = 2'd2;

   // Status codes
   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_RAISED    = 3'd1;
   localparam status_type ST_LOWERED   = 3'd2;
   localparam status_type ST_REMOVED   = 3'd3;
   localparam status_type ST_NOT_FOUND = 3'd4;
   localparam status_type ST_FULL      = 3'd5;
   localparam status_type ST_LISTED    = 3'd6;
   localparam status_type ST_EMPTY     = 3'd7;

   localparam qty_type QTY_ONE = qty_type'(1);

   // One table entry
   typedef struct packed {
      key_type key;
      qty_type qty;
   } entry_type;

   // Store write request
   typedef struct packed {
      logic      en;
      idx_type   addr;
      entry_type data;
   } wr_type;

   // Compare/step unit result
   typedef struct packed {
      logic    lt;
      logic    eq;
      logic    above_one;
      qty_type step;
   } alu_type;

   // Result beat handed to the output register
   typedef struct packed {
      logic       valid;
      status_type status;
      key_type    key;
      qty_type    qty;
      logic       last;
   } emit_type;

endpackage

// ----- hw/rtl/sckt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckt_req_if: request channel
// Valid/ready channel carrying one op and one item number per beat.
// ----------------------------------------------------------------------------
interface sckt_req_if;
   import sckt_pkg::*;

   logic    valid;
   logic    ready;
   op_type  op;
   key_type item_number;

   modport source (output valid, output op, output item_number, input ready);
   modport sink   (input valid, input op, input item_number, output ready);
endinterface

// ----- hw/rtl/sckt_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckt_rsp_if: response channel
// Valid/ready channel carrying one result beat: status, key, quantity, last.
// ----------------------------------------------------------------------------
interface sckt_rsp_if;
   import sckt_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   key_type    entry_key;
   qty_type    quantity;
   logic       last;

   modport source (output valid, output status, output entry_key, output quantity,
                   output last, input ready);
   modport sink   (input valid, input status, input entry_key, input quantity,
                   input last, output ready);
endinterface

// ----- hw/rtl/sckt_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckt_store: entry store
// Single write port, single read port table of key/quantity entries with
// registered read data.
// ----------------------------------------------------------------------------
module sckt_store (
   input  logic                clock,
   input  sckt_pkg::wr_type    wr,
   input  sckt_pkg::idx_type   rd_addr,
   output sckt_pkg::entry_type rd_entry
);
   import sckt_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rd_entry_ff;

   // Write the requested entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ----- hw/rtl/sckt_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckt_alu: shared compare and quantity step unit
// Compares a stored key against the search key and steps the stored
// quantity up (saturating) or down by one.
// ----------------------------------------------------------------------------
module sckt_alu (
   input  sckt_pkg::entry_type entry,
   input  sckt_pkg::key_type   key,
   input  logic                dec,
   output sckt_pkg::alu_type   res
);
   import sckt_pkg::*;

   qty_type sum;

   // One adder serves both directions: add all ones to step down
   assign sum = entry.qty + (dec ? {QTY_W{1'b1}} : QTY_ONE);

   always_comb begin
      res.lt        = entry.key < key;
      res.eq        = entry.key == key;
      res.above_one = entry.qty > QTY_ONE;
      // Hold a saturated quantity on the way up
      res.step      = (!dec && (&entry.qty)) ? entry.qty : sum;
   end

endmodule

// ----- hw/rtl/sckt_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckt_seq: table sequencer
// Walks the store one entry a cycle to search, shift for insert or removal,
// and list (when the output is free); drives compare/step, emits result beats.
// ----------------------------------------------------------------------------
module sckt_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  sckt_pkg::op_type    req_op,
   input  sckt_pkg::key_type   req_item_number,
   output logic                req_ready,
   input  logic                out_free,
   output sckt_pkg::emit_type  emit,
   output sckt_pkg::wr_type    wr,
   output sckt_pkg::idx_type   rd_addr,
   input  sckt_pkg::entry_type rd_entry,
   output logic                alu_dec,
   output sckt_pkg::key_type   alu_key,
   input  sckt_pkg::alu_type   alu
);
   import sckt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SEARCH   = 6'b000010,
      S_SHIFT_UP = 6'b000100,
      S_INSERT   = 6'b001000,
      S_SHIFT_DN = 6'b010000,
      S_LIST     = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   cnt_type   used_ff, used_in;
   cnt_type   pos_ff, pos_in;
   cnt_type   idx_ff, idx_in;
   key_type   key_ff, key_in;
   op_type    op_ff, op_in;

   logic    has_entries;
   logic    below;
   logic    found;
   cnt_type pos_next;
   cnt_type idx_next;
   cnt_type idx_prev;
   cnt_type used_last;

   assign has_entries = used_ff != '0;
   assign below       = has_entries && alu.lt;
   assign found       = has_entries && alu.eq;
   assign pos_next    = pos_ff + cnt_type'(1);
   assign idx_next    = idx_ff + cnt_type'(1);
   assign idx_prev    = idx_ff - cnt_type'(1);
   assign used_last   = used_ff - cnt_type'(1);

   assign alu_dec = op_ff == OP_SUB;
   assign alu_key = key_ff;

   // Sequence one op
   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      key_in    = key_ff;
      op_in     = op_ff;
      rd_addr   = idx_ff[IDX_W-1:0];
      wr        = '0;
      emit      = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = '0;
            if (req_valid) begin
               key_in = req_item_number;
               op_in  = req_op;
               pos_in = '0;
               idx_in = '0;
               if (req_op == OP_ADD || req_op == OP_SUB) begin
                  state_in = S_SEARCH;
               end else if (req_op == OP_LIST) begin
                  state_in = S_LIST;
               end
            end
         end

         S_SEARCH: begin
            rd_addr = pos_ff[IDX_W-1:0];
            if (below && pos_next < used_ff) begin
               // advance to the next stored key
               pos_in  = pos_next;
               rd_addr = pos_next[IDX_W-1:0];
            end else if (out_free) begin
               state_in = S_IDLE;
               if (op_ff == OP_ADD) begin
                  if (found) begin
                     wr.en      = 1'b1;
                     wr.addr    = pos_ff[IDX_W-1:0];
                     wr.data    = '{key: key_ff, qty: alu.step};
                     emit       = '{valid: 1'b1, status: ST_RAISED, key: key_ff,
                                    qty: alu.step, last: 1'b1};
                  end else if (used_ff == cnt_type'(CAPACITY)) begin
                     emit       = '{valid: 1'b1, status: ST_FULL, key: key_ff,
                                    qty: '0, last: 1'b1};
                  end else if (below) begin
                     // new key goes past the end
                     pos_in   = used_ff;
                     state_in = S_INSERT;
                  end else if (!has_entries) begin
                     state_in = S_INSERT;
                  end else begin
                     // open a slot at pos by shifting the tail up
                     idx_in   = used_last;
                     rd_addr  = used_last[IDX_W-1:0];
                     state_in = S_SHIFT_UP;
                  end
               end else begin
                  if (!found) begin
                     emit = '{valid: 1'b1, status: ST_NOT_FOUND, key: key_ff,
                              qty: '0, last: 1'b1};
                  end else if (alu.above_one) begin
                     wr.en   = 1'b1;
                     wr.addr = pos_ff[IDX_W-1:0];
                     wr.data = '{key: key_ff, qty: alu.step};
                     emit    = '{valid: 1'b1, status: ST_LOWERED, key: key_ff,
                                 qty: alu.step, last: 1'b1};
                  end else if (pos_next < used_ff) begin
                     // close the gap by shifting the tail down
                     idx_in   = pos_next;
                     rd_addr  = pos_next[IDX_W-1:0];
                     state_in = S_SHIFT_DN;
                  end else begin
                     used_in = used_last;
                     emit    = '{valid: 1'b1, status: ST_REMOVED, key: key_ff,
                                 qty: '0, last: 1'b1};
                  end
               end
            end
         end

         S_SHIFT_UP: begin
            wr.en   = 1'b1;
            wr.addr = idx_next[IDX_W-1:0];
            wr.data = rd_entry;
            if (idx_ff == pos_ff) begin
               state_in = S_INSERT;
            end else begin
               idx_in  = idx_prev;
               rd_addr = idx_prev[IDX_W-1:0];
            end
         end

         S_INSERT: begin
            if (out_free) begin
               wr.en    = 1'b1;
               wr.addr  = pos_ff[IDX_W-1:0];
               wr.data  = '{key: key_ff, qty: QTY_ONE};
               used_in  = used_ff + cnt_type'(1);
               emit     = '{valid: 1'b1, status: ST_INSERTED, key: key_ff,
                            qty: QTY_ONE, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_SHIFT_DN: begin
            if (idx_next < used_ff) begin
               wr.en   = 1'b1;
               wr.addr = idx_prev[IDX_W-1:0];
               wr.data = rd_entry;
               idx_in  = idx_next;
               rd_addr = idx_next[IDX_W-1:0];
            end else if (out_free) begin
               wr.en    = 1'b1;
               wr.addr  = idx_prev[IDX_W-1:0];
               wr.data  = rd_entry;
               used_in  = used_last;
               emit     = '{valid: 1'b1, status: ST_REMOVED, key: key_ff,
                            qty: '0, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_LIST: begin
            if (!has_entries) begin
               if (out_free) begin
                  emit     = '{valid: 1'b1, status: ST_EMPTY, key: '0,
                               qty: '0, last: 1'b1};
                  state_in = S_IDLE;
               end
            end else if (out_free) begin
               emit = '{valid: 1'b1, status: ST_LISTED, key: rd_entry.key,
                        qty: rd_entry.qty, last: idx_next == used_ff};
               if (idx_next == used_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_next;
                  rd_addr = idx_next[IDX_W-1:0];
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      key_ff <= key_in;
      op_ff  <= op_in;
   end

endmodule

// ----- hw/rtl/sorted_counted_key_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_counted_key_table: sorted table of keys with quantities
// Adds, subtracts and lists keys kept in ascending order, each with a
// saturating quantity; one sequencer walks a one-read, one-write port store.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload                          | handshake
//  req_bus | in  | op, item_number                       | valid/ready
//  rsp_bus | out | status, entry_key, quantity, last     | valid/ready
//
// Add/subtract: after the idle state takes the request, a search walks up to
// the lower-bound position; its last step writes a raise or lower and loads
// the answer. An insert then shifts each entry from that position up and
// writes the key; a removal shifts each entry behind it down. List: after
// the idle state, one beat per stored entry, or one empty beat.
// Reset empties the table at once; no clearing pass.
// A stalled response holds the sequencer at its next result beat; a new
// request is taken as soon as the sequencer is idle.
// ----------------------------------------------------------------------------
module sorted_counted_key_table (
   input  logic  clock,
   input  logic  reset,
   sckt_req_if.sink   req_bus,
   sckt_rsp_if.source rsp_bus
);
   import sckt_pkg::*;

   emit_type  emit;
   wr_type    wr;
   idx_type   rd_addr;
   entry_type rd_entry;
   alu_type   alu;
   logic      alu_dec;
   key_type   alu_key;
   logic      out_free;

   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   key_type    rsp_key_ff;
   qty_type    rsp_qty_ff;
   logic       rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   sckt_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_op          (req_bus.op),
      .req_item_number (req_bus.item_number),
      .req_ready       (req_bus.ready),
      .out_free        (out_free),
      .emit            (emit),
      .wr              (wr),
      .rd_addr         (rd_addr),
      .rd_entry        (rd_entry),
      .alu_dec         (alu_dec),
      .alu_key         (alu_key),
      .alu             (alu)
   );

   sckt_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   sckt_alu u_alu (
      .entry (rd_entry),
      .key   (alu_key),
      .dec   (alu_dec),
      .res   (alu)
   );

   // Output register valid: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_status_ff <= emit.status;
         rsp_key_ff    <= emit.key;
         rsp_qty_ff    <= emit.qty;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.entry_key = rsp_key_ff;
   assign rsp_bus.quantity  = rsp_qty_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule

// ----- tb/tb_sorted_counted_key_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_counted_key_table: self-checking bench for the sorted key table
// Drives add, subtract and list requests. A shadow copy of the sorted table
// predicts every response beat, and each beat is checked in order. Runs a
// directed part and random traffic under several idle and stall mixes on
// both channels.
// ----------------------------------------------------------------------------
module tb_sorted_counted_key_table;
   import sckt_pkg::*;

   localparam int WATCHDOG_CYCLES = 2000000;
   localparam int RANDOM_PER_MIX  = 38;
   localparam int MAX_REPORTS     = 40;

   typedef struct packed {
      op_type  op;
      key_type item_number;
   } table_req_t;

   typedef struct packed {
      status_type status;
      key_type    entry_key;
      qty_type    quantity;
      logic       last;
   } table_beat_t;

   logic clock;
   logic reset;

   sckt_req_if req_bus ();
   sckt_rsp_if rsp_bus ();

   sorted_counted_key_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow table and traffic bookkeeping
   key_type     shadow_keys [CAPACITY];
   qty_type     shadow_qtys [CAPACITY];
   int          shadow_used;
   table_req_t  pending_reqs [$];
   table_beat_t expected_beats [$];
   logic        req_taken;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          error_count;
   int          reqs_accepted;
   int          beats_checked;
   int          status_seen [8];
   int          cycle_count;

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Update the shadow table for one accepted request and queue its beats
   function automatic void predict_table(op_type op, key_type key);
      int pos;
      pos = 0;
      while (pos < shadow_used && shadow_keys[pos] < key) pos++;
      case (op)
         OP_ADD: begin
            if (pos < shadow_used && shadow_keys[pos] == key) begin
               if (shadow_qtys[pos] != {QTY_W{1'b1}}) begin
                  shadow_qtys[pos] = shadow_qtys[pos] + QTY_ONE;
               end
               expected_beats.push_back(table_beat_t'{ST_RAISED, key, shadow_qtys[pos], 1'b1});
            end else if (shadow_used >= CAPACITY) begin
               expected_beats.push_back(table_beat_t'{ST_FULL, key, '0, 1'b1});
            end else begin
               for (int i = shadow_used; i > pos; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_qtys[i] = shadow_qtys[i-1];
               end
               shadow_keys[pos] = key;
               shadow_qtys[pos] = QTY_ONE;
               shadow_used++;
               expected_beats.push_back(table_beat_t'{ST_INSERTED, key, QTY_ONE, 1'b1});
            end
         end
         OP_SUB: begin
            if (pos >= shadow_used || shadow_keys[pos] != key) begin
               expected_beats.push_back(table_beat_t'{ST_NOT_FOUND, key, '0, 1'b1});
            end else if (shadow_qtys[pos] > QTY_ONE) begin
               shadow_qtys[pos] = shadow_qtys[pos] - QTY_ONE;
               expected_beats.push_back(table_beat_t'{ST_LOWERED, key, shadow_qtys[pos], 1'b1});
            end else begin
               for (int i = pos; i + 1 < shadow_used; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_qtys[i] = shadow_qtys[i+1];
               end
               shadow_used--;
               expected_beats.push_back(table_beat_t'{ST_REMOVED, key, '0, 1'b1});
            end
         end
         OP_LIST: begin
            if (shadow_used == 0) begin
               expected_beats.push_back(table_beat_t'{ST_EMPTY, '0, '0, 1'b1});
            end else begin
               for (int i = 0; i < shadow_used; i++) begin
                  expected_beats.push_back(table_beat_t'{ST_LISTED, shadow_keys[i],
                                                         shadow_qtys[i], i + 1 == shadow_used});
               end
            end
         end
         default: begin
            // reserved op: no state change, no beat
         end
      endcase
   endfunction

   task automatic queue_req(op_type op, key_type key);
      pending_reqs.push_back(table_req_t'{op, key});
   endtask

   // Hold until every queued request is taken and every beat has arrived
   task automatic drain_traffic();
      while (pending_reqs.size() != 0 || expected_beats.size() != 0) @(posedge clock);
   endtask

   // Random traffic: mostly adds and subtracts over a small key pool, some lists,
   // a little noise with any op and any key
   task automatic queue_random(int count);
      int roll;
      key_type pool_key;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         pool_key = key_type'($urandom_range(19) * 862);
         if ($urandom_range(9) == 0) pool_key = {KEY_W{1'b1}};
         if (roll < 6) begin
            queue_req(op_type'($urandom_range(3)), key_type'($urandom_range(16383)));
         end else if (roll < 56) begin
            queue_req(OP_ADD, pool_key);
         end else if (roll < 88) begin
            queue_req(OP_SUB, pool_key);
         end else begin
            queue_req(OP_LIST, key_type'($urandom_range(16383)));
         end
      end
   endtask

   // Driver: present requests and set response ready at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_bus.valid       <= 1'b1;
               req_bus.op          <= pending_reqs[0].op;
               req_bus.item_number <= pending_reqs[0].item_number;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: check response beats, then record accepted request beats
   always @(posedge clock) begin
      table_beat_t got;
      table_beat_t want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = table_beat_t'{rsp_bus.status, rsp_bus.entry_key, rsp_bus.quantity,
                                rsp_bus.last};
            if (expected_beats.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected beat status %0d key %0d qty %0d last %0d", $time,
                           got.status, got.entry_key, got.quantity, got.last);
               end
            end else begin
               want = expected_beats.pop_front();
               beats_checked++;
               status_seen[want.status]++;
               if (got !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t: mismatch expected status %0d key %0d qty %0d last %0d, actual status %0d key %0d qty %0d last %0d",
                              $time, want.status, want.entry_key, want.quantity, want.last,
                              got.status, got.entry_key, got.quantity, got.last);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_table(req_bus.op, req_bus.item_number);
            void'(pending_reqs.pop_front());
            reqs_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // Watchdog: fail and end the run if it outlasts the watchdog limit
   initial begin
      cycle_count = 0;
      while (cycle_count < WATCHDOG_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_sorted_counted_key_table failed");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_ADD;
      req_bus.item_number = '0;
      rsp_bus.ready       = 1'b0;
      req_taken           = 1'b0;
      shadow_used         = 0;
      error_count         = 0;
      reqs_accepted       = 0;
      beats_checked       = 0;
      sender_idle_pct     = 0;
      receiver_stall_pct  = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         shadow_keys[i] = '0;
         shadow_qtys[i] = '0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty list, raise/lower/remove, absent key, reserved op
      queue_req(OP_LIST, key_type'(1234));
      queue_req(OP_ADD, key_type'(9999));
      queue_req(OP_ADD, key_type'(9999));
      queue_req(OP_SUB, key_type'(9999));
      queue_req(OP_SUB, key_type'(9999));
      queue_req(OP_SUB, key_type'(9999));
      queue_req(op_type'(3), key_type'(777));
      // Key above the item range, both key extremes and a middle insert
      queue_req(OP_ADD, {KEY_W{1'b1}});
      queue_req(OP_ADD, '0);
      queue_req(OP_ADD, key_type'(5000));
      // Fill the table, then hit it while full
      for (int b = 0; b < 13; b++) queue_req(OP_ADD, key_type'(1 << b));
      queue_req(OP_ADD, key_type'(8192));
      queue_req(OP_ADD, key_type'(5000));
      queue_req(OP_LIST, '0);
      queue_req(OP_SUB, key_type'(64));
      queue_req(OP_ADD, key_type'(8192));
      queue_req(OP_LIST, {KEY_W{1'b1}});
      drain_traffic();

      // Random traffic under each idle/stall mix
      for (int mix = 0; mix < 4; mix++) begin
         sender_idle_pct    = (mix == 1) ? 54 : (mix == 3) ? 13 : 0;
         receiver_stall_pct = (mix == 2) ? 54 : (mix == 3) ? 13 : 0;
         queue_random(RANDOM_PER_MIX);
         drain_traffic();
      end

      // Let any stray beat show up before closing
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (60) @(posedge clock);

      $display("Accepted %0d requests (directed plus four idle/stall mixes), checked %0d beats",
               reqs_accepted, beats_checked);
      $display("Beats by status: ins %0d rai %0d low %0d rem %0d nf %0d full %0d lst %0d emp %0d",
               status_seen[ST_INSERTED], status_seen[ST_RAISED], status_seen[ST_LOWERED],
               status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
               status_seen[ST_LISTED], status_seen[ST_EMPTY]);
      if (error_count == 0) begin
         $display("tb_sorted_counted_key_table passed");
      end else begin
         $display("tb_sorted_counted_key_table failed");
      end
      $finish;
   end

endmodule
